/* src/odq_pkg.sv */
// ----------------------------------------------------------------------------
// odq_pkg
// Shared types for the overwriting circular deque: request opcodes, error
// codes, cell commands and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package odq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_INSERT     = 3'd5,
    OP_ERASE      = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_RANGE = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    CMD_HOLD          = 4'd0,
    CMD_APPEND        = 4'd1,
    CMD_SHIFT_IN_BACK = 4'd2,
    CMD_SHIFT_RIGHT   = 4'd3,
    CMD_SHIFT_LEFT    = 4'd4,
    CMD_INSERT        = 4'd5,
    CMD_INSERT_FULL   = 4'd6,
    CMD_ERASE         = 4'd7,
    CMD_ROTATE        = 4'd8
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

/* src/overwriting_circular_deque.sv */
// ----------------------------------------------------------------------------
// overwriting_circular_deque
// Byte deque with a configured capacity, built as a chain of element cells
// kept in logical order, with a request sequencer and a registered result.
// ----------------------------------------------------------------------------
// Each request on the slave stream (opcode in tuser) produces one result
// transaction on the master stream. A read rotates the stored elements once
// past the head cell and an erase shifts the chain once per removed element
// before the result is formed. One request is worked on at a time, and the
// next one is accepted while a result waits on the master side. The capacity
// register is written through cfg_wr_en and cfg_wr_data; a write is only
// taken while the deque is empty, 0 reads as 1 and values above DEPTH read as
// DEPTH.
`default_nettype none

module overwriting_circular_deque #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wr_en,
  input  wire logic [$clog2(DEPTH + 1)-1:0] cfg_wr_data,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // Fields from bit 0 up: data_in, position, range_end, zero fill.
  input  wire logic [((DATA_WIDTH + 2 * $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // Fields from bit 0 up: opcode.
  input  wire logic [2:0]           s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // Fields from bit 0 up: data_out, error_code, fill_level, is_empty,
  // is_full, zero fill.
  output logic [((DATA_WIDTH + $clog2(DEPTH + 1) + 4 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int CW       = $clog2(DEPTH + 1);
  localparam int IN_BITS  = DATA_WIDTH + 2 * CW;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = DATA_WIDTH + 2 + CW + 2;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  odq_pkg::state_t state;
  odq_pkg::op_t    op_q;
  odq_pkg::err_t   err_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [CW-1:0]   pos_q;
  logic [CW-1:0]   end_q;
  logic [CW-1:0]   count;
  logic [CW-1:0]   capacity;
  logic [CW-1:0]   step;
  logic [CW-1:0]   step_last;
  logic [DATA_WIDTH-1:0] rd_q;
  logic            out_valid;
  logic [OUT_BITS-1:0] out_data;

  odq_pkg::state_t state_next;
  odq_pkg::err_t   err_next;
  odq_pkg::cmd_t   cmd;
  logic [CW-1:0]   cmd_pos;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   step_next;
  logic [CW-1:0]   step_last_next;
  logic [DATA_WIDTH-1:0] rd_next;
  logic            full;
  logic            empty;
  logic            s_accept;
  logic            out_free;

  logic [DATA_WIDTH-1:0] cell_val [DEPTH];

  assign full     = (count == capacity);
  assign empty    = (count == '0);
  assign s_axis_tready = (state == odq_pkg::ST_IDLE);
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'(out_data);

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_val;
    logic [DATA_WIDTH-1:0] right_val;
    if (k == 0) begin : g_first
      assign left_val = data_q;
    end else begin : g_inner_l
      assign left_val = cell_val[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_val = cell_val[k];
    end else begin : g_inner_r
      assign right_val = cell_val[k+1];
    end
    odq_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .CNT_W     (CW),
      .INDEX     (k)
    ) u_cell (
      .clk  (clk),
      .cmd  (cmd),
      .pos  (cmd_pos),
      .data (data_q),
      .left (left_val),
      .right(right_val),
      .head (cell_val[0]),
      .value(cell_val[k])
    );
  end

  always_comb begin
    state_next     = state;
    err_next       = err_q;
    cmd            = odq_pkg::CMD_HOLD;
    cmd_pos        = '0;
    count_next     = count;
    step_next      = step;
    step_last_next = step_last;
    rd_next        = rd_q;
    case (state)
      odq_pkg::ST_IDLE: begin
        if (s_accept) begin
          state_next = odq_pkg::ST_EXEC;
          err_next   = odq_pkg::ERR_OK;
          rd_next    = '0;
        end
      end
      odq_pkg::ST_EXEC: begin
        state_next = odq_pkg::ST_DONE;
        case (op_q)
          odq_pkg::OP_PUSH_BACK: begin
            if (full) begin
              cmd     = odq_pkg::CMD_SHIFT_IN_BACK;
              cmd_pos = capacity - ONE_C;
            end else begin
              cmd        = odq_pkg::CMD_APPEND;
              cmd_pos    = count;
              count_next = count + ONE_C;
            end
          end
          odq_pkg::OP_PUSH_FRONT: begin
            cmd = odq_pkg::CMD_SHIFT_RIGHT;
            if (!full) count_next = count + ONE_C;
          end
          odq_pkg::OP_POP_BACK: begin
            if (empty) err_next = odq_pkg::ERR_EMPTY;
            else count_next = count - ONE_C;
          end
          odq_pkg::OP_POP_FRONT: begin
            if (empty) begin
              err_next = odq_pkg::ERR_EMPTY;
            end else begin
              cmd        = odq_pkg::CMD_SHIFT_LEFT;
              count_next = count - ONE_C;
            end
          end
          odq_pkg::OP_READ: begin
            if (pos_q >= count) begin
              err_next = odq_pkg::ERR_RANGE;
            end else begin
              state_next     = odq_pkg::ST_SHIFT;
              step_next      = '0;
              step_last_next = count - ONE_C;
            end
          end
          odq_pkg::OP_INSERT: begin
            if (pos_q > count) begin
              err_next = odq_pkg::ERR_RANGE;
            end else if (full) begin
              cmd     = odq_pkg::CMD_INSERT_FULL;
              cmd_pos = (pos_q >= capacity) ? capacity - ONE_C : pos_q;
            end else begin
              cmd        = odq_pkg::CMD_INSERT;
              cmd_pos    = pos_q;
              count_next = count + ONE_C;
            end
          end
          odq_pkg::OP_ERASE: begin
            if (pos_q >= end_q || end_q > count) begin
              err_next = odq_pkg::ERR_RANGE;
            end else begin
              state_next     = odq_pkg::ST_SHIFT;
              step_next      = '0;
              step_last_next = end_q - pos_q - ONE_C;
            end
          end
          odq_pkg::OP_CLEAR: count_next = '0;
          default: count_next = count;
        endcase
      end
      odq_pkg::ST_SHIFT: begin
        if (op_q == odq_pkg::OP_READ) begin
          cmd     = odq_pkg::CMD_ROTATE;
          cmd_pos = count - ONE_C;
          if (step == pos_q) rd_next = cell_val[0];
        end else begin
          cmd     = odq_pkg::CMD_ERASE;
          cmd_pos = pos_q;
        end
        step_next = step + ONE_C;
        if (step == step_last) begin
          state_next = odq_pkg::ST_DONE;
          if (op_q == odq_pkg::OP_ERASE) count_next = count - (end_q - pos_q);
        end
      end
      odq_pkg::ST_DONE: begin
        if (out_free) state_next = odq_pkg::ST_IDLE;
      end
      default: state_next = odq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= odq_pkg::ST_IDLE;
      count     <= '0;
      capacity  <= DEPTH_C;
      out_valid <= 1'b0;
      err_q     <= odq_pkg::ERR_OK;
      step      <= '0;
      step_last <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      err_q     <= err_next;
      step      <= step_next;
      step_last <= step_last_next;
      if (cfg_wr_en && empty) begin
        if (cfg_wr_data == '0) capacity <= ONE_C;
        else if (cfg_wr_data > DEPTH_C) capacity <= DEPTH_C;
        else capacity <= cfg_wr_data;
      end
      if (state == odq_pkg::ST_DONE && out_free) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= rd_next;
    if (s_accept) begin
      op_q   <= odq_pkg::op_t'(s_axis_tuser);
      data_q <= s_axis_tdata[DATA_WIDTH-1:0];
      pos_q  <= s_axis_tdata[DATA_WIDTH+CW-1:DATA_WIDTH];
      end_q  <= s_axis_tdata[DATA_WIDTH+2*CW-1:DATA_WIDTH+CW];
    end
    if (state == odq_pkg::ST_DONE && out_free) begin
      out_data <= {full, empty, count, err_q, rd_q};
    end
  end

endmodule

`default_nettype wire

/* src/odq_cell.sv */
// ----------------------------------------------------------------------------
// odq_cell
// One element slot of the deque chain. The cell holds the element at its own
// logical index and, under a broadcast command, keeps it, loads new data or
// takes the value of its left or right neighbor or of the head cell.
// ----------------------------------------------------------------------------
`default_nettype none

module odq_cell #(
  parameter int DATA_WIDTH = 8,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk,
  input  wire odq_pkg::cmd_t         cmd,
  input  wire logic [CNT_W-1:0]      pos,
  input  wire logic [DATA_WIDTH-1:0] data,
  input  wire logic [DATA_WIDTH-1:0] left,
  input  wire logic [DATA_WIDTH-1:0] right,
  input  wire logic [DATA_WIDTH-1:0] head,
  output logic      [DATA_WIDTH-1:0] value
);

  localparam logic [CNT_W-1:0] K = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] value_next;

  always_comb begin
    value_next = value;
    case (cmd)
      odq_pkg::CMD_HOLD: value_next = value;
      odq_pkg::CMD_APPEND: begin
        if (K == pos) value_next = data;
      end
      odq_pkg::CMD_SHIFT_IN_BACK: begin
        value_next = (K == pos) ? data : right;
      end
      odq_pkg::CMD_SHIFT_RIGHT: value_next = left;
      odq_pkg::CMD_SHIFT_LEFT: value_next = right;
      odq_pkg::CMD_INSERT: begin
        if (K == pos) value_next = data;
        else if (K > pos) value_next = left;
      end
      odq_pkg::CMD_INSERT_FULL: begin
        if (K == pos) value_next = data;
        else if (K < pos) value_next = right;
      end
      odq_pkg::CMD_ERASE: begin
        if (K >= pos) value_next = right;
      end
      odq_pkg::CMD_ROTATE: begin
        value_next = (K == pos) ? head : right;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire
